// ===== rtl/kss_pkg.sv =====
// kss_pkg: sizes, state encoding and field widths of the k-th smallest selector
// used by kss_if.sv and kth_smallest_select_core.sv; depends on nothing
package kss_pkg;

  localparam int MaxLength = 1024;
  localparam int AddrW     = $clog2(MaxLength);
  localparam int CntW      = $clog2(MaxLength + 1);
  localparam int ValueW    = 32;
  localparam int RankW     = 11;
  localparam int CmpW      = (CntW > RankW) ? CntW : RankW;
  localparam int SumW      = CntW + 1;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [AddrW-1:0]         addr_t;
  typedef logic [CntW-1:0]          cnt_t;
  typedef logic [RankW-1:0]         rank_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_PIVOT_RD,
    ST_PIVOT_CAP,
    ST_SCAN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/kss_if.sv =====
// kss_elem_if / kss_result_if: valid-ready channels of the k-th smallest selector
// depends on kss_pkg for field types
interface kss_elem_if;
  logic           valid;
  logic           ready;
  kss_pkg::value_t element_value;
  kss_pkg::rank_t  wanted_rank;
  logic           last_element;

  modport source (output valid, output element_value, output wanted_rank,
                  output last_element, input ready);
  modport sink   (input valid, input element_value, input wanted_rank,
                  input last_element, output ready);
endinterface

interface kss_result_if;
  logic           valid;
  logic           ready;
  kss_pkg::value_t selected_value;
  logic           rank_error;

  modport source (output valid, output selected_value, output rank_error, input ready);
  modport sink   (input valid, input selected_value, input rank_error, output ready);
endinterface

// ===== rtl/kth_smallest_select_core.sv =====
// Loading: one element per cycle, an element request is taken every cycle in load state.
// After the last element: a check state, then per partition pass a pivot read, pivot
// capture, streamed read of the source memory and decision; worst case quadratic.
// Reset (synchronous, rst high) clears control state only; element memories are not cleared.
// Result is held in an output register, so loading the next vector overlaps its wait.
// kth_smallest_select_core: quickselect over two ping-pong element memories
// depends on kss_pkg and kss_if.sv
module kth_smallest_select_core (
  input  logic                 clk,
  input  logic                 rst,
  kss_elem_if.sink             elem,
  kss_result_if.source         result
);

  // element memories, one read and one write port each
  kss_pkg::value_t mem_a [kss_pkg::MaxLength];
  kss_pkg::value_t mem_b [kss_pkg::MaxLength];
  kss_pkg::value_t rd_a;
  kss_pkg::value_t rd_b;

  kss_pkg::state_t state;
  kss_pkg::state_t state_next;

  kss_pkg::cnt_t   loaded_count;
  kss_pkg::rank_t  held_rank;
  kss_pkg::addr_t  lo;
  kss_pkg::addr_t  hi;
  kss_pkg::addr_t  target;
  kss_pkg::value_t pivot;
  kss_pkg::cnt_t   scan_idx;
  kss_pkg::cnt_t   lt_cnt;
  kss_pkg::cnt_t   gt_cnt;
  logic            rd_pend;
  logic            src_sel;
  kss_pkg::value_t res_value;
  logic            res_error;

  logic            out_valid;
  kss_pkg::value_t out_value;
  logic            out_error;

  // combinational control
  logic            accept;
  logic            load_we;
  logic            rd_en;
  kss_pkg::addr_t  rd_addr;
  kss_pkg::value_t rd_data;
  logic            scan_issue;
  logic            scan_we;
  kss_pkg::addr_t  scan_waddr;
  logic            is_less;
  logic            is_greater;
  logic            rank_bad;
  logic            out_free;
  logic [kss_pkg::SumW-1:0] lt_end;
  logic [kss_pkg::SumW-1:0] tgt_gt;
  logic [kss_pkg::SumW-1:0] lo_wr;
  logic [kss_pkg::SumW-1:0] hi_wr;
  logic [kss_pkg::SumW-1:0] mid_sum;
  logic [kss_pkg::CmpW-1:0] rank_ext;
  logic [kss_pkg::CmpW-1:0] count_ext;
  logic [kss_pkg::CmpW-1:0] rank_m1;

  assign accept   = elem.valid && elem.ready;
  assign rd_data  = src_sel ? rd_b : rd_a;
  assign out_free = !out_valid || result.ready;

  assign is_less    = rd_data < pivot;
  assign is_greater = rd_data > pivot;

  assign rank_ext  = kss_pkg::CmpW'(held_rank);
  assign count_ext = kss_pkg::CmpW'(loaded_count);
  assign rank_bad  = (rank_ext == '0) || (rank_ext > count_ext);
  assign rank_m1   = rank_ext - kss_pkg::CmpW'(1);

  assign lt_end  = kss_pkg::SumW'(lo) + kss_pkg::SumW'(lt_cnt);
  assign tgt_gt  = kss_pkg::SumW'(target) + kss_pkg::SumW'(gt_cnt);
  assign lo_wr   = kss_pkg::SumW'(lo) + kss_pkg::SumW'(lt_cnt);
  assign hi_wr   = kss_pkg::SumW'(hi) - kss_pkg::SumW'(gt_cnt);
  assign mid_sum = kss_pkg::SumW'(lo) + kss_pkg::SumW'((hi - lo) >> 1);

  // target below the end of the less-than region
  function automatic logic SumW_lt(input kss_pkg::addr_t t,
                                   input logic [kss_pkg::SumW-1:0] e);
    return kss_pkg::SumW'(t) < e;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kss_pkg::ST_LOAD: begin
        if (accept && elem.last_element) state_next = kss_pkg::ST_CHECK;
      end
      kss_pkg::ST_CHECK: begin
        state_next = rank_bad ? kss_pkg::ST_RESULT : kss_pkg::ST_PIVOT_RD;
      end
      kss_pkg::ST_PIVOT_RD: state_next = kss_pkg::ST_PIVOT_CAP;
      kss_pkg::ST_PIVOT_CAP: begin
        state_next = (lo == hi) ? kss_pkg::ST_RESULT : kss_pkg::ST_SCAN;
      end
      kss_pkg::ST_SCAN: begin
        if (!scan_issue && !rd_pend) state_next = kss_pkg::ST_DECIDE;
      end
      kss_pkg::ST_DECIDE: begin
        priority if (SumW_lt(target, lt_end)) state_next = kss_pkg::ST_PIVOT_RD;
        else if (tgt_gt > kss_pkg::SumW'(hi)) state_next = kss_pkg::ST_PIVOT_RD;
        else state_next = kss_pkg::ST_RESULT;
      end
      kss_pkg::ST_RESULT: begin
        if (out_free) state_next = kss_pkg::ST_LOAD;
      end
      default: state_next = kss_pkg::ST_LOAD;
    endcase
  end

  // state outputs: memory ports and handshake
  always_comb begin
    elem.ready = 1'b0;
    load_we    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    scan_issue = 1'b0;
    scan_we    = 1'b0;
    scan_waddr = '0;
    unique case (state)
      kss_pkg::ST_LOAD: begin
        elem.ready = 1'b1;
        load_we    = accept && (loaded_count < kss_pkg::CntW'(kss_pkg::MaxLength));
      end
      kss_pkg::ST_PIVOT_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid_sum[kss_pkg::AddrW-1:0];
      end
      kss_pkg::ST_SCAN: begin
        scan_issue = scan_idx <= kss_pkg::CntW'(hi);
        rd_en      = scan_issue;
        rd_addr    = scan_idx[kss_pkg::AddrW-1:0];
        scan_we    = rd_pend && (is_less || is_greater);
        scan_waddr = is_less ? lo_wr[kss_pkg::AddrW-1:0] : hi_wr[kss_pkg::AddrW-1:0];
      end
      default: begin
      end
    endcase
  end

  // memory a: load writes and pass writes when b is the source
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_a[loaded_count[kss_pkg::AddrW-1:0]] <= elem.element_value;
    end else if (scan_we && src_sel) begin
      mem_a[scan_waddr] <= rd_data;
    end
    if (rd_en) begin
      rd_a <= mem_a[rd_addr];
    end
  end

  // memory b: pass writes when a is the source
  always_ff @(posedge clk) begin
    if (scan_we && !src_sel) begin
      mem_b[scan_waddr] <= rd_data;
    end
    if (rd_en) begin
      rd_b <= mem_b[rd_addr];
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kss_pkg::ST_LOAD;
      loaded_count <= '0;
      held_rank    <= '0;
      rd_pend      <= 1'b0;
      src_sel      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // output register: set on a finished selection, cleared on acceptance
      if (state == kss_pkg::ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        kss_pkg::ST_LOAD: begin
          if (load_we) loaded_count <= loaded_count + kss_pkg::CntW'(1);
          if (accept && elem.last_element) held_rank <= elem.wanted_rank;
        end
        kss_pkg::ST_CHECK: begin
          lo           <= '0;
          hi           <= kss_pkg::AddrW'(loaded_count - kss_pkg::CntW'(1));
          target       <= rank_m1[kss_pkg::AddrW-1:0];
          src_sel      <= 1'b0;
          res_value    <= '0;
          res_error    <= rank_bad;
          loaded_count <= '0;
        end
        kss_pkg::ST_PIVOT_CAP: begin
          pivot     <= rd_data;
          res_value <= rd_data;
          res_error <= 1'b0;
          scan_idx  <= kss_pkg::CntW'(lo);
          lt_cnt    <= '0;
          gt_cnt    <= '0;
          rd_pend   <= 1'b0;
        end
        kss_pkg::ST_SCAN: begin
          rd_pend <= scan_issue;
          if (scan_issue) scan_idx <= scan_idx + kss_pkg::CntW'(1);
          if (rd_pend && is_less) lt_cnt <= lt_cnt + kss_pkg::CntW'(1);
          if (rd_pend && is_greater) gt_cnt <= gt_cnt + kss_pkg::CntW'(1);
        end
        kss_pkg::ST_DECIDE: begin
          // keep the side that holds the target, or finish on the pivot band
          priority if (SumW_lt(target, lt_end)) begin
            hi      <= kss_pkg::AddrW'(lt_end - kss_pkg::SumW'(1));
            src_sel <= !src_sel;
          end else if (tgt_gt > kss_pkg::SumW'(hi)) begin
            lo      <= kss_pkg::AddrW'(hi_wr + kss_pkg::SumW'(1));
            src_sel <= !src_sel;
          end else begin
            res_value <= pivot;
            res_error <= 1'b0;
          end
        end
        kss_pkg::ST_RESULT: begin
          if (out_free) begin
            out_value <= res_value;
            out_error <= res_error;
            src_sel   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.selected_value = out_value;
  assign result.rank_error     = out_error;

endmodule

// ===== tb/kss_checker.sv =====
`timescale 1ns / 100ps
// kss_checker: watches the element and result channels of the k-th smallest selector,
// predicts each result from the accepted element requests and compares field by field
// depends on kss_pkg and the channel interfaces of rtl/kss_if.sv
module kss_checker (
  input  logic         clk,
  input  logic         rst,
  kss_elem_if          elem,
  kss_result_if        result,
  output int           pending,
  output int           fail_count
);

  typedef struct packed {
    kss_pkg::value_t selected_value;
    logic            rank_error;
  } selection_t;

  kss_pkg::value_t vector_q[$];
  selection_t      selection_q[$];
  int              mismatch_total = 0;

  // k-th smallest by counting: the wanted value has fewer than k entries below it
  // and at least k entries at or below it
  function automatic kss_pkg::value_t kth_smallest(input int k);
    int              below;
    int              upto;
    kss_pkg::value_t cand;
    foreach (vector_q[i]) begin
      cand  = vector_q[i];
      below = 0;
      upto  = 0;
      foreach (vector_q[j]) begin
        if (vector_q[j] < cand) below++;
        if (vector_q[j] <= cand) upto++;
      end
      if (below < k && k <= upto) return cand;
    end
    return '0;
  endfunction

  // store one element request, close the vector on the last flag
  task automatic take_element(input kss_pkg::value_t v, input kss_pkg::rank_t r,
                              input logic l);
    selection_t sel;
    if (vector_q.size() < kss_pkg::MaxLength) vector_q.push_back(v);
    if (l) begin
      if (r == '0 || int'(r) > vector_q.size()) begin
        sel.selected_value = '0;
        sel.rank_error     = 1'b1;
      end else begin
        sel.selected_value = kth_smallest(int'(r));
        sel.rank_error     = 1'b0;
      end
      selection_q.push_back(sel);
      vector_q.delete();
    end
  endtask

  // compare one result with the oldest prediction
  task automatic check_result(input kss_pkg::value_t v, input logic e);
    selection_t sel;
    if (selection_q.size() == 0) begin
      $error("result with no request pending: selected_value %0d rank_error %0b", v, e);
      mismatch_total++;
    end else begin
      sel = selection_q.pop_front();
      if (e !== sel.rank_error) begin
        $error("rank_error mismatch: expected %0b, actual %0b", sel.rank_error, e);
        mismatch_total++;
      end
      if (v !== sel.selected_value) begin
        $error("selected_value mismatch: expected %0d, actual %0d", sel.selected_value, v);
        mismatch_total++;
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      vector_q.delete();
      selection_q.delete();
    end else begin
      if (elem.valid && elem.ready)
        take_element(elem.element_value, elem.wanted_rank, elem.last_element);
      if (result.valid && result.ready)
        check_result(result.selected_value, result.rank_error);
    end
    pending    <= selection_q.size();
    fail_count <= mismatch_total;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for kth_smallest_select_core, directed vectors then random ones
// depends on kss_pkg, rtl/kss_if.sv, the core and tb/kss_checker.sv
module tb_top;

  typedef enum int {PACE_CALM, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} pace_t;
  typedef enum int {VAL_FULL, VAL_TINY, VAL_Q16, VAL_EXTREME} value_kind_t;

  localparam int CycleLimit   = 1000000;
  localparam int RandomItems  = 250;
  localparam int LongHold     = 600;
  localparam int SettleCycles = 64;

  logic clk;
  logic rst;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   pending;
  int   fail_count;
  int   cycle_count = 0;

  kss_elem_if   elem_ch ();
  kss_result_if result_ch ();

  kth_smallest_select_core uut (
    .clk    (clk),
    .rst    (rst),
    .elem   (elem_ch),
    .result (result_ch)
  );

  kss_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .elem       (elem_ch),
    .result     (result_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_CALM: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      PACE_TX_IDLE: begin
        tx_idle_pct  = 63;
        rx_stall_pct = 0;
      end
      PACE_RX_STALL: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 63;
      end
      default: begin
        tx_idle_pct  = 25;
        rx_stall_pct = 25;
      end
    endcase
  endtask

  // one element request; valid stays high after acceptance for back-to-back requests
  task automatic send_element(input kss_pkg::value_t v, input kss_pkg::rank_t r,
                              input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      elem_ch.valid <= 1'b0;
      @(posedge clk);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= v;
    elem_ch.wanted_rank   <= r;
    elem_ch.last_element  <= l;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    elem_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic kss_pkg::value_t pick_value(input value_kind_t kind);
    case (kind)
      VAL_FULL: return $urandom;
      VAL_TINY: return $signed($urandom_range(6)) - 3;
      VAL_Q16:  return $signed($urandom_range(200 << 16)) - (100 << 16);
      default: begin
        case ($urandom_range(4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // one vector: len elements, rank on the last, noise rank on the rest
  task automatic send_vector(input int len, input kss_pkg::rank_t r);
    value_kind_t kind;
    kind = value_kind_t'($urandom_range(3));
    for (int i = 0; i < len; i++)
      send_element(pick_value(kind), (i == len - 1) ? r : kss_pkg::rank_t'($urandom),
                   i == len - 1);
  endtask

  // random length, mostly valid ranks, some out of range
  task automatic send_random_vector();
    int             len;
    int             sel;
    kss_pkg::rank_t r;
    len = ($urandom_range(99) < 80) ? $urandom_range(1, 16) : $urandom_range(17, 64);
    sel = $urandom_range(99);
    if (sel < 6) r = '0;
    else if (sel < 12) r = kss_pkg::rank_t'($urandom_range(len + 1, 2047));
    else if (sel < 15) r = kss_pkg::rank_t'($urandom_range(1024, 2047));
    else if (sel < 30) r = kss_pkg::rank_t'(len);
    else r = kss_pkg::rank_t'($urandom_range(1, len));
    send_vector(len, r);
  endtask

  initial begin
    int phase;
    rst                   = 1'b1;
    elem_ch.valid         = 1'b0;
    elem_ch.element_value = '0;
    elem_ch.wanted_rank   = '0;
    elem_ch.last_element  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single elements, extremes, bad ranks, duplicates, fractions
    set_pace(PACE_BOTH);
    send_element(32'sh8000_0000, 11'd1, 1'b1);
    send_element(32'sh7fff_ffff, 11'd0, 1'b1);
    send_element(32'sd5, 11'd2, 1'b1);
    send_element(32'sh7fff_ffff, 11'd0, 1'b0);
    send_element(32'sh8000_0000, 11'd0, 1'b0);
    send_element(32'sd0, 11'd3, 1'b1);
    send_element(32'sh7fff_ffff, 11'd2047, 1'b0);
    send_element(32'sh8000_0000, 11'd2047, 1'b0);
    send_element(32'sd0, 11'd1, 1'b1);
    send_element(-32'sd1, 11'd0, 1'b0);
    send_element(32'sd1, 11'd2047, 1'b1);
    for (int i = 0; i < 4; i++) send_element(32'sd7, 11'd2, i == 3);
    send_element(32'sd3, 11'd0, 1'b0);
    send_element(32'sd1, 11'd0, 1'b0);
    send_element(32'sd2, 11'd1024, 1'b1);
    send_element(32'sh0001_0000, 11'd0, 1'b0);
    send_element(32'shffff_0000, 11'd0, 1'b0);
    send_element(32'sh0000_8000, 11'd0, 1'b0);
    send_element(32'shffff_8000, 11'd2, 1'b1);
    wait_drained();

    // result side held off while requests keep coming, so the core backs up
    set_pace(PACE_CALM);
    hold_left = LongHold;
    repeat (8) send_vector($urandom_range(6, 12), 11'd3);
    wait_drained();

    // one vector at a time, sender waits for each result
    set_pace(PACE_BOTH);
    repeat (10) begin
      send_random_vector();
      wait_drained();
    end

    // store full: overflow with rank at the limit
    set_pace(PACE_BOTH);
    send_vector(kss_pkg::MaxLength + 2, 11'd1024);
    wait_drained();

    // random vectors, pacing rotates every four vectors
    items_sent = 0;
    phase = 0;
    while (items_sent < RandomItems) begin
      set_pace(pace_t'(phase % 4));
      repeat (4) send_random_vector();
      phase++;
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
